// ===== src/ppm_pkg.sv =====
package ppm_pkg;

	// Filter store geometry
	localparam int FILTER_DEPTH = 8;
	localparam int FD_AW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam int FD_SW = 16 + FD_AW;

	// Divider: |num| < 2**26, |den| <= 65535
	localparam int DIV_NW = 27;
	localparam int DIV_DW = 16;
	localparam int DIV_CW = $clog2(DIV_NW);

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_RANGE_HIGH  = 3'd0;
	localparam logic [2:0] REG_RANGE_LOW   = 3'd1;
	localparam logic [2:0] REG_TOP_EDGE    = 3'd2;
	localparam logic [2:0] REG_BOTTOM_EDGE = 3'd3;
	localparam logic [2:0] REG_LEFT_EDGE   = 3'd4;

	typedef enum logic [2:0] {
		TOP_IDLE,
		TOP_MUL,
		TOP_DIVGO,
		TOP_DIVW,
		TOP_FILTGO,
		TOP_FILTW,
		TOP_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		AVG_IDLE,
		AVG_RD0,
		AVG_CHK,
		AVG_FILL,
		AVG_WR,
		AVG_SUM,
		AVG_TAIL,
		AVG_DONE
	} avg_state_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
		logic              rem_nz;
	} div_rsp_t;

	typedef struct packed {
		logic        done;
		logic [15:0] avg;
	} avg_rsp_t;

endpackage

// ===== src/ppm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module ppm_div
	import ppm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output div_rsp_t          rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// Shift in the next dividend bit and try to subtract
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], fits};
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quo    = quo_q;
	assign rsp.rem_nz = rem_q != '0;

endmodule

// ===== src/ppm_avg.sv =====
// Box moving average over a small synchronous store.
// Entry 0 empty: fill all entries with the new value. Otherwise write at
// the pointer, then sweep all entries to form the sum.
module ppm_avg
	import ppm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        go,
	input  logic [15:0] value,
	output avg_rsp_t    rsp
);

	avg_state_t state_q, state_d;

	logic [15:0]       mem [FILTER_DEPTH];
	logic [FILTER_DEPTH-1:0] vld_q;
	logic [15:0]       rd_data_q;
	logic              rd_ok_q;
	logic              rd_pend_q;
	logic [15:0]       rd_val;

	logic              we;
	logic [FD_AW-1:0]  wa;
	logic [FD_AW-1:0]  ra;
	logic              rd_issue;

	logic [FD_AW-1:0]  idx_q;
	logic [FD_AW-1:0]  wp_q;
	logic [FD_SW-1:0]  acc_q;
	logic [15:0]       val_q;
	logic              fill_q;
	logic              idx_last;

	assign rd_val   = rd_ok_q ? rd_data_q : 16'd0;
	assign idx_last = idx_q == FD_AW'(FILTER_DEPTH - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			AVG_IDLE: if (go) state_d = AVG_RD0;
			AVG_RD0:  state_d = AVG_CHK;
			AVG_CHK:  state_d = (rd_val == 16'd0) ? AVG_FILL : AVG_WR;
			AVG_FILL: if (idx_last) state_d = AVG_DONE;
			AVG_WR:   state_d = AVG_SUM;
			AVG_SUM:  if (idx_last) state_d = AVG_TAIL;
			AVG_TAIL: state_d = AVG_DONE;
			AVG_DONE: state_d = AVG_IDLE;
			default:  state_d = AVG_IDLE;
		endcase
	end

	// Memory controls
	always_comb begin
		we       = 1'b0;
		wa       = idx_q;
		ra       = idx_q;
		rd_issue = 1'b0;
		case (state_q)
			AVG_RD0: ra = '0;
			AVG_FILL: begin
				we = 1'b1;
				wa = idx_q;
			end
			AVG_WR: begin
				we = 1'b1;
				wa = wp_q;
			end
			AVG_SUM: rd_issue = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= AVG_IDLE;
		else state_q <= state_d;
	end

	// Store, registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= val_q;
		rd_data_q <= mem[ra];
	end

	// Valid bits: an entry never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_ok_q   <= 1'b0;
			rd_pend_q <= 1'b0;
			wp_q      <= '0;
		end else begin
			if (clr) vld_q <= '0;
			else if (we) vld_q[wa] <= 1'b1;
			rd_ok_q   <= vld_q[ra];
			rd_pend_q <= rd_issue;
			if (state_q == AVG_WR)
				wp_q <= (wp_q == FD_AW'(FILTER_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		end
	end

	// Sequencing datapath
	always_ff @(posedge clk) begin
		if (state_q == AVG_IDLE && go) val_q <= value;
		case (state_q)
			AVG_CHK: begin
				idx_q  <= '0;
				fill_q <= rd_val == 16'd0;
			end
			AVG_WR:   idx_q <= '0;
			AVG_FILL: idx_q <= idx_q + 1'b1;
			AVG_SUM:  idx_q <= idx_q + 1'b1;
			default: ;
		endcase
		if (state_q == AVG_WR) acc_q <= '0;
		else if (rd_pend_q) acc_q <= acc_q + FD_SW'(rd_val);
	end

	assign rsp.done = state_q == AVG_DONE;
	assign rsp.avg  = fill_q ? val_q : 16'(acc_q / FD_SW'(FILTER_DEPTH));

endmodule

// ===== src/plot_point_mapper.sv =====
// One item at a time: a new input item is taken only after the result of the last
// has been loaded into the output register. The 27-step divider and the sweep
// over the filter store take most of the time per item, and output stalls add
// to it; matching range bounds skip the divider, and a store refill skips the sum sweep.
// Reset: registers return to their defaults, filter store reads as empty,
// write pointer and column count are zero, no result pending.
module plot_point_mapper
	import ppm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] sample
	input  logic        s_axis_tuser,  // [0] start_of_pass
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [10:0] x_pixel, [20:11] y_pixel, rest zero
);

	top_state_t state_q, state_d;

	logic [15:0] high_q, low_q;
	logic [9:0]  top_q, bot_q, left_q;
	logic [9:0]  col_q, col_next;

	logic        accept;
	logic        cfg_we;
	logic [2:0]  cfg_idx;

	logic [15:0]        sample_q;
	logic [10:0]        x_q;
	logic signed [27:0] num_q;
	logic signed [16:0] den_q;
	logic [15:0]        mapped_q;
	logic [9:0]         y_q;

	logic signed [16:0] diff_c;
	logic signed [10:0] span_c;
	logic signed [27:0] num_c;
	logic signed [16:0] den_c;
	logic [DIV_NW-1:0]  num_mag;
	logic [DIV_DW-1:0]  den_mag;
	logic [27:0]        q_abs, q_fl;
	logic               q_neg;
	logic [15:0]        y1;

	logic     div_go, avg_go, load_out;
	div_rsp_t div_rsp;
	avg_rsp_t avg_rsp;

	logic        m_valid_q;
	logic [23:0] m_data_q;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_we  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= 16'd10500;
			low_q  <= 16'd9500;
			top_q  <= 10'd75;
			bot_q  <= 10'd315;
			left_q <= 10'd70;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RANGE_HIGH:  high_q <= pwdata[15:0];
				REG_RANGE_LOW:   low_q  <= pwdata[15:0];
				REG_TOP_EDGE:    top_q  <= pwdata[9:0];
				REG_BOTTOM_EDGE: bot_q  <= pwdata[9:0];
				REG_LEFT_EDGE:   left_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_RANGE_HIGH:  prdata = {16'd0, high_q};
			REG_RANGE_LOW:   prdata = {16'd0, low_q};
			REG_TOP_EDGE:    prdata = {22'd0, top_q};
			REG_BOTTOM_EDGE: prdata = {22'd0, bot_q};
			REG_LEFT_EDGE:   prdata = {22'd0, left_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			TOP_IDLE:   if (s_axis_tvalid) state_d = TOP_MUL;
			TOP_MUL:    state_d = TOP_DIVGO;
			TOP_DIVGO:  state_d = (den_q == '0) ? TOP_FILTGO : TOP_DIVW;
			TOP_DIVW:   if (div_rsp.done) state_d = TOP_FILTGO;
			TOP_FILTGO: state_d = TOP_FILTW;
			TOP_FILTW:  if (avg_rsp.done) state_d = TOP_OUT;
			TOP_OUT:    if (!m_valid_q || m_axis_tready) state_d = TOP_IDLE;
			default:    state_d = TOP_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		div_go        = 1'b0;
		avg_go        = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			TOP_IDLE:   s_axis_tready = 1'b1;
			TOP_DIVGO:  div_go = den_q != '0;
			TOP_FILTGO: avg_go = 1'b1;
			TOP_OUT:    load_out = !m_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= TOP_IDLE;
		else state_q <= state_d;
	end

	assign accept   = s_axis_tvalid & s_axis_tready;
	assign col_next = s_axis_tuser ? 10'd0 : col_q;

	// Column count advances per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) col_q <= '0;
		else if (accept) col_q <= col_next + 10'd1;
	end

	// Linear map: product and range width
	assign diff_c = $signed({1'b0, sample_q}) - $signed({1'b0, low_q});
	assign span_c = $signed({1'b0, top_q}) - $signed({1'b0, bot_q});
	assign num_c  = 28'(diff_c) * 28'(span_c);
	assign den_c  = $signed({1'b0, high_q}) - $signed({1'b0, low_q});

	assign num_mag = num_q[27] ? DIV_NW'(-num_q) : num_q[DIV_NW-1:0];
	assign den_mag = den_q[16] ? DIV_DW'(-den_q) : den_q[DIV_DW-1:0];

	// Floor correction on the magnitude quotient
	assign q_neg = num_q[27] ^ den_q[16];
	assign q_abs = {1'b0, div_rsp.quo};
	assign q_fl  = q_neg ? (28'd0 - q_abs - 28'(div_rsp.rem_nz)) : q_abs;

	// Clamp: top first, then bottom
	assign y1 = (avg_rsp.avg < {6'd0, top_q}) ? {6'd0, top_q} : avg_rsp.avg;

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_axis_tdata;
			x_q      <= 11'(left_q) + 11'(col_next);
		end
		if (state_q == TOP_MUL) begin
			num_q <= num_c;
			den_q <= den_c;
		end
		if (state_q == TOP_DIVGO && den_q == '0) mapped_q <= {6'd0, bot_q};
		if (state_q == TOP_DIVW && div_rsp.done) mapped_q <= 16'(q_fl + 28'(bot_q));
		if (state_q == TOP_FILTW && avg_rsp.done)
			y_q <= (y1 > {6'd0, bot_q}) ? bot_q : y1[9:0];
	end

	ppm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (num_mag),
		.den    (den_mag),
		.rsp    (div_rsp)
	);

	ppm_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept & s_axis_tuser),
		.go     (avg_go),
		.value  (mapped_q),
		.rsp    (avg_rsp)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (load_out) m_valid_q <= 1'b1;
		else if (m_axis_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) m_data_q <= {3'd0, y_q, x_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Checks
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == TOP_DIVW)
		else $error("divider finished outside its wait state");

	a_avg_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		avg_rsp.done |-> state_q == TOP_FILTW)
		else $error("filter finished outside its wait state");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second item accepted while one is in work");

	a_y_in_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && top_q <= bot_q) |->
		(m_axis_tdata[20:11] >= top_q && m_axis_tdata[20:11] <= bot_q))
		else $error("y outside graph rows");

endmodule

// ===== dv/tb_top.sv =====
module tb_top
	import ppm_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 64;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] sample
	logic        s_axis_tuser;   // [0] start_of_pass
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [10:0] x_pixel, [20:11] y_pixel, rest zero

	bit quiet;      // no idling on either side
	bit gaps_on;    // sender gaps allowed in this phase
	bit stalls_on;  // receiver stalls allowed in this phase

	plot_point_mapper dut (.*);

	// Tracks registers and filter state, predicts one point per sample
	class plot_scoreboard;
		typedef struct packed {
			logic [10:0] x;
			logic [9:0]  y;
		} point_t;

		bit [15:0] range_high;
		bit [15:0] range_low;
		bit [9:0]  top_edge;
		bit [9:0]  bottom_edge;
		bit [9:0]  left_edge;
		bit [15:0] taps [FILTER_DEPTH];
		int        wr_ptr;
		bit [9:0]  col;
		point_t    expected_points[$];
		int        errors;

		function new();
			range_high  = 16'd10500;
			range_low   = 16'd9500;
			top_edge    = 10'd75;
			bottom_edge = 10'd315;
			left_edge   = 10'd70;
			foreach (taps[i])
				taps[i] = '0;
			wr_ptr = 0;
			col    = '0;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(input logic [2:0] idx, input logic [31:0] val);
			case (idx)
				REG_RANGE_HIGH:  range_high  = val[15:0];
				REG_RANGE_LOW:   range_low   = val[15:0];
				REG_TOP_EDGE:    top_edge    = val[9:0];
				REG_BOTTOM_EDGE: bottom_edge = val[9:0];
				REG_LEFT_EDGE:   left_edge   = val[9:0];
				default: ;
			endcase
		endfunction

		// Linear map with floor division, wrapped to 16 bits
		function bit [15:0] map_row(input bit [15:0] smp);
			longint den;
			longint num;
			longint q;
			den = longint'(range_high) - longint'(range_low);
			if (den == 0)
				return {6'd0, bottom_edge};
			num = (longint'(smp) - longint'(range_low)) *
			      (longint'(top_edge) - longint'(bottom_edge));
			q = num / den;
			if ((num % den) != 0 && ((num < 0) != (den < 0)))
				q = q - 1;
			q = q + longint'(bottom_edge);
			return q[15:0];
		endfunction

		function void note_sample(input bit [15:0] smp, input bit sop);
			bit [15:0] mapped;
			bit [15:0] avg;
			bit [31:0] total;
			point_t    pt;
			if (sop) begin
				foreach (taps[i])
					taps[i] = '0;
				col = '0;
			end
			mapped = map_row(smp);
			// empty store refills with the new value
			if (taps[0] == 16'd0) begin
				foreach (taps[i])
					taps[i] = mapped;
				avg = mapped;
			end else begin
				taps[wr_ptr] = mapped;
				wr_ptr = (wr_ptr + 1) % FILTER_DEPTH;
				total = 0;
				foreach (taps[i])
					total += taps[i];
				avg = 16'(total / FILTER_DEPTH);
			end
			// clamp order matters when edges are crossed
			if (avg < top_edge)
				avg = {6'd0, top_edge};
			if (avg > bottom_edge)
				avg = {6'd0, bottom_edge};
			pt.x = {1'b0, left_edge} + {1'b0, col};
			pt.y = avg[9:0];
			col  = col + 10'd1;
			expected_points.push_back(pt);
		endfunction

		task check_point(input logic [23:0] data);
			point_t want;
			if (expected_points.size() == 0) begin
				report($sformatf("unexpected point tdata=%h", data));
				return;
			end
			want = expected_points.pop_front();
			if (data[10:0] !== want.x)
				report($sformatf("x_pixel got %0d want %0d", data[10:0], want.x));
			if (data[20:11] !== want.y)
				report($sformatf("y_pixel got %0d want %0d", data[20:11], want.y));
			if (data[23:21] !== 3'd0)
				report($sformatf("tdata pad bits not zero: %h", data));
		endtask
	endclass

	plot_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Observe handshakes, feed the scoreboard, run the watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (psel && penable && pwrite && pready) begin
			sb.set_reg(paddr[4:2], pwdata);
			moved = 1'b1;
		end
		if (s_axis_tvalid && s_axis_tready) begin
			sb.note_sample(s_axis_tdata, s_axis_tuser);
			moved = 1'b1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_point(m_axis_tdata);
			moved = 1'b1;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no progress", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stall bursts
	initial begin
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!quiet && stalls_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic push_sample(input bit [15:0] smp, input bit sop);
		s_axis_tdata  <= smp;
		s_axis_tuser  <= sop;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		// optional gap after the item
		if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stop sending until every predicted point has come back
	task automatic wait_points_drained();
		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input int unsigned hi, input int unsigned lo,
	                         input int unsigned top, input int unsigned bot,
	                         input int unsigned left);
		wait_points_drained();
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_TOP_EDGE, top);
		write_reg(REG_BOTTOM_EDGE, bot);
		write_reg(REG_LEFT_EDGE, left);
	endtask

	// One random phase: pick settings, then stream samples
	task automatic run_phase(input int kind, input int n_items, input bit one_pass);
		int unsigned v;
		int unsigned lo;
		int unsigned s_min;
		int unsigned s_max;
		bit [15:0]   smp;
		bit          sop;
		case (kind)
			0: load_regs(65535, 0, 0, 1023, 1023);
			1: load_regs(0, 65535, 1023, 0, 0);
			2: begin
				v = $urandom_range(0, 65535);
				load_regs(v, v, $urandom_range(0, 400), $urandom_range(400, 1023),
				          $urandom_range(0, 1023));
			end
			3: load_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
			             $urandom_range(0, 1023), $urandom_range(0, 1023),
			             $urandom_range(0, 1023));
			5: load_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
			             $urandom_range(512, 1023), $urandom_range(0, 511),
			             $urandom_range(0, 1023));
			default: begin
				lo = $urandom_range(0, 60000);
				load_regs(lo + $urandom_range(1, 5000), lo, $urandom_range(0, 400),
				          $urandom_range(500, 1023), $urandom_range(0, 1023));
			end
		endcase
		s_min = (sb.range_low < sb.range_high) ? sb.range_low : sb.range_high;
		s_max = (sb.range_low < sb.range_high) ? sb.range_high : sb.range_low;
		gaps_on   = $urandom_range(0, 3) != 0;
		stalls_on = $urandom_range(0, 3) != 0;
		for (int n = 0; n < n_items; n++) begin
			case ($urandom_range(0, 9))
				0: smp = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
				1, 2, 3: smp = 16'($urandom_range(0, 65535));
				default: smp = 16'($urandom_range(s_min, s_max));
			endcase
			sop = (n == 0) || (!one_pass && $urandom_range(0, 39) == 0);
			if (one_pass && n == 800)
				quiet = 1'b1;
			push_sample(smp, sop);
			if (!quiet && $urandom_range(0, 199) == 0)
				wait_points_drained();
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		quiet     = 1'b0;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, range ends and sample extremes
		push_sample(16'd9500, 1'b1);
		push_sample(16'd10500, 1'b0);
		push_sample(16'd10000, 1'b0);
		push_sample(16'd0, 1'b0);
		push_sample(16'd65535, 1'b0);
		// mapped row of zero: store refills
		push_sample(16'd10812, 1'b1);
		push_sample(16'd10000, 1'b0);
		repeat (5) push_sample(16'd10812, 1'b0);
		push_sample(16'd9800, 1'b0);
		// equal range bounds
		load_regs(4000, 4000, 75, 315, 70);
		push_sample(16'd4000, 1'b1);
		push_sample(16'd0, 1'b0);
		push_sample(16'd65535, 1'b0);
		// crossed edges
		load_regs(10500, 9500, 600, 200, 0);
		push_sample(16'd100, 1'b1);
		push_sample(16'd65535, 1'b0);
		push_sample(16'd30000, 1'b0);

		// Random phases over several settings
		run_phase(0, 100, 1'b0);
		run_phase(1, 100, 1'b0);
		wait_points_drained();
		run_phase(2, 100, 1'b0);
		run_phase(3, 100, 1'b0);
		run_phase(4, 100, 1'b0);
		run_phase(5, 100, 1'b0);
		run_phase(3, 100, 1'b0);
		run_phase(4, 100, 1'b0);
		// one long pass so the column count wraps
		run_phase(4, 1030, 1'b1);

		wait_points_drained();
		if (sb.errors == 0 && sb.expected_points.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/ppm_pkg.sv
src/ppm_div.sv
src/ppm_avg.sv
src/plot_point_mapper.sv
dv/tb_top.sv
